@@ src/lms_pkg.sv @@
// Package for the LED mode sequencer: mode and register index codes,
// reset values of the configuration registers and fixed duty constants.
// No dependencies.
`default_nettype none

package lms_pkg;

    // Operating modes, in the order the mode button steps through them
    typedef enum logic [1:0] {
        MODE_OFF   = 2'd0,
        MODE_BLINK = 2'd1,
        MODE_ON    = 2'd2,
        MODE_FADE  = 2'd3
    } mode_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_LOCKOUT      = 2'd0,
        CFG_BLINK_PERIOD = 2'd1,
        CFG_FADE_PERIOD  = 2'd2,
        CFG_FADE_STEP    = 2'd3
    } cfg_index_t;

    localparam int ELAPSED_W = 9;
    localparam int DUTY_W    = 8;
    localparam int CFG_W     = 9;

    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = 9'd511;
    localparam logic [DUTY_W-1:0]    DUTY_FULL   = 8'd255;
    localparam logic [DUTY_W-1:0]    DUTY_ZERO   = 8'd0;
    localparam logic [DUTY_W-1:0]    PURPLE_OFS  = 8'd50;

    localparam logic [ELAPSED_W-1:0] LOCKOUT_RST      = 9'd300;
    localparam logic [ELAPSED_W-1:0] BLINK_PERIOD_RST = 9'd500;
    localparam logic [ELAPSED_W-1:0] FADE_PERIOD_RST  = 9'd10;
    localparam logic [DUTY_W-1:0]    FADE_STEP_RST    = 8'd5;

endpackage

`default_nettype wire

@@ src/lms_tick_if.sv @@
// Input channel of the LED mode sequencer: one beat per millisecond tick
// with the two active-low button levels. No dependencies.
`default_nettype none

interface lms_tick_if;
    logic valid;
    logic ready;
    logic mode_button_level;
    logic reset_button_level;

    modport source (output valid, output mode_button_level, output reset_button_level,
                    input ready);
    modport sink   (input valid, input mode_button_level, input reset_button_level,
                    output ready);
endinterface

`default_nettype wire

@@ src/lms_result_if.sv @@
// Output channel of the LED mode sequencer: one beat per tick with the
// three LED duties and the current mode. No dependencies.
`default_nettype none

interface lms_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_duty;
    logic [7:0] blue_duty;
    logic [7:0] purple_duty;
    logic [1:0] current_mode;

    modport source (output valid, output red_duty, output blue_duty,
                    output purple_duty, output current_mode, input ready);
    modport sink   (input valid, input red_duty, input blue_duty,
                    input purple_duty, input current_mode, output ready);
endinterface

`default_nettype wire

@@ src/lms_cfg_if.sv @@
// Configuration write channel of the LED mode sequencer: register index
// and write data per beat. No dependencies.
`default_nettype none

interface lms_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [8:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ src/led_mode_sequencer.sv @@
// Top level of the LED mode sequencer: button edge detection with lockout,
// mode stepping, blink and fade duty generation, output register with skid.
// Depends on lms_pkg, lms_tick_if, lms_result_if and lms_cfg_if.
`default_nettype none

// The block takes one tick beat per clock cycle while its skid entry is
// free and gives one registered result beat per tick. All of the
// per-tick work (elapsed counters, button edges, mode step, blink toggle,
// fade step) is one pass of combinational logic into the state and result
// registers; an output register plus one skid entry keep the tick side
// accepting while a result waits, so back-to-back ticks run at full rate
// as long as the result side takes its beats. Configuration writes are
// always accepted and take effect on the next tick.
module led_mode_sequencer (
    input  wire           clk,
    input  wire           rst_n,
    lms_tick_if.sink      tick,
    lms_result_if.source  result,
    lms_cfg_if.sink       cfg
);
    import lms_pkg::*;

    typedef struct packed {
        logic [DUTY_W-1:0] red;
        logic [DUTY_W-1:0] blue;
        logic [DUTY_W-1:0] purple;
        mode_t             mode;
    } res_t;

    // Configuration registers
    logic [ELAPSED_W-1:0] lockout_reg;
    logic [ELAPSED_W-1:0] blink_period_reg;
    logic [ELAPSED_W-1:0] fade_period_reg;
    logic [DUTY_W-1:0]    fade_step_reg;

    // Sequencer state
    mode_t                mode_reg, mode_next;
    logic                 prev_mb_reg, prev_rb_reg;
    logic [ELAPSED_W-1:0] since_press_reg, since_press_next;
    logic [ELAPSED_W-1:0] since_update_reg, since_update_next;
    logic                 blink_on_reg, blink_on_next;
    logic [DUTY_W-1:0]    fade_level_reg, fade_level_next;
    logic                 fade_rising_reg, fade_rising_next;
    logic [DUTY_W-1:0]    red_reg, red_next;
    logic [DUTY_W-1:0]    blue_reg, blue_next;
    logic [DUTY_W-1:0]    purple_reg, purple_next;

    // Output register and skid entry
    res_t out_reg, skid_reg, res_new;
    logic out_valid_reg, skid_valid_reg;

    logic tick_accept;
    logic [ELAPSED_W-1:0] sp_inc, su_inc;
    logic mode_fire, reset_fire;
    logic [DUTY_W:0]      fade_sum;
    logic [DUTY_W-1:0]    fade_lvl;

    assign cfg.ready   = 1'b1;
    assign tick.ready  = !skid_valid_reg;
    assign tick_accept = tick.valid && tick.ready;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lockout_reg      <= LOCKOUT_RST;
            blink_period_reg <= BLINK_PERIOD_RST;
            fade_period_reg  <= FADE_PERIOD_RST;
            fade_step_reg    <= FADE_STEP_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg_index_t'(cfg.index))
                CFG_LOCKOUT:      lockout_reg      <= cfg.data;
                CFG_BLINK_PERIOD: blink_period_reg <= cfg.data;
                CFG_FADE_PERIOD:  fade_period_reg  <= cfg.data;
                CFG_FADE_STEP:    fade_step_reg    <= cfg.data[DUTY_W-1:0];
                default:          ;
            endcase
        end
    end

    // Compute the next state for one tick
    always_comb
    begin
        sp_inc = (since_press_reg >= ELAPSED_MAX) ? ELAPSED_MAX
                                                  : since_press_reg + 9'd1;
        su_inc = (since_update_reg >= ELAPSED_MAX) ? ELAPSED_MAX
                                                   : since_update_reg + 9'd1;

        // A mode press drops a reset press on the same tick; a press clears the elapsed time
        mode_fire  = !tick.mode_button_level && prev_mb_reg && (sp_inc > lockout_reg);
        reset_fire = !tick.reset_button_level && prev_rb_reg && (sp_inc > lockout_reg)
                     && !mode_fire;

        mode_next        = mode_reg;
        since_press_next = sp_inc;
        if (mode_fire)
        begin
            mode_next        = mode_t'(mode_reg + 2'd1);
            since_press_next = '0;
        end
        else if (reset_fire)
        begin
            mode_next        = MODE_OFF;
            since_press_next = '0;
        end

        since_update_next = su_inc;
        blink_on_next     = blink_on_reg;
        fade_level_next   = fade_level_reg;
        fade_rising_next  = fade_rising_reg;
        red_next          = red_reg;
        blue_next         = blue_reg;
        purple_next       = purple_reg;

        // Step the fade level with clamping at both ends
        fade_sum = {1'b0, fade_level_reg} + {1'b0, fade_step_reg};
        if (fade_rising_reg)
            fade_lvl = fade_sum[DUTY_W] ? DUTY_FULL : fade_sum[DUTY_W-1:0];
        else
            fade_lvl = (fade_step_reg >= fade_level_reg) ? DUTY_ZERO
                                                         : fade_level_reg - fade_step_reg;

        // Run the action of the mode after this tick's press
        unique case (mode_next)
            MODE_OFF:
            begin
                red_next    = DUTY_ZERO;
                blue_next   = DUTY_ZERO;
                purple_next = DUTY_ZERO;
            end
            MODE_BLINK:
            begin
                if (su_inc >= blink_period_reg)
                begin
                    blink_on_next     = !blink_on_reg;
                    red_next          = blink_on_reg ? DUTY_ZERO : DUTY_FULL;
                    blue_next         = red_next;
                    purple_next       = red_next;
                    since_update_next = '0;
                end
            end
            MODE_ON:
            begin
                red_next    = DUTY_FULL;
                blue_next   = DUTY_FULL;
                purple_next = DUTY_FULL;
            end
            MODE_FADE:
            begin
                if (su_inc >= fade_period_reg)
                begin
                    fade_level_next = fade_lvl;
                    if (fade_lvl == DUTY_FULL || fade_lvl == DUTY_ZERO)
                        fade_rising_next = !fade_rising_reg;
                    red_next          = fade_lvl;
                    blue_next         = DUTY_FULL - fade_lvl;
                    purple_next       = {1'b0, fade_lvl[DUTY_W-1:1]} + PURPLE_OFS;
                    since_update_next = '0;
                end
            end
            default: ;
        endcase

        res_new.red    = red_next;
        res_new.blue   = blue_next;
        res_new.purple = purple_next;
        res_new.mode   = mode_next;
    end

    // Advance the sequencer state on each accepted tick beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_OFF;
            prev_mb_reg      <= 1'b1;
            prev_rb_reg      <= 1'b1;
            since_press_reg  <= '0;
            since_update_reg <= '0;
            blink_on_reg     <= 1'b0;
            fade_level_reg   <= '0;
            fade_rising_reg  <= 1'b1;
            red_reg          <= '0;
            blue_reg         <= '0;
            purple_reg       <= '0;
        end
        else if (tick_accept)
        begin
            mode_reg         <= mode_next;
            prev_mb_reg      <= tick.mode_button_level;
            prev_rb_reg      <= tick.reset_button_level;
            since_press_reg  <= since_press_next;
            since_update_reg <= since_update_next;
            blink_on_reg     <= blink_on_next;
            fade_level_reg   <= fade_level_next;
            fade_rising_reg  <= fade_rising_next;
            red_reg          <= red_next;
            blue_reg         <= blue_next;
            purple_reg       <= purple_next;
        end
    end

    // Hold results in the output register, spill to skid when stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || result.ready)
        begin
            out_valid_reg  <= skid_valid_reg || tick_accept;
            skid_valid_reg <= 1'b0;
        end
        else if (tick_accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || result.ready)
        begin
            out_reg <= skid_valid_reg ? skid_reg : res_new;
        end
        else if (tick_accept)
        begin
            skid_reg <= res_new;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.red_duty     = out_reg.red;
    assign result.blue_duty    = out_reg.blue;
    assign result.purple_duty  = out_reg.purple;
    assign result.current_mode = out_reg.mode;

`ifndef NO_ASSERTIONS
    // Skid entry is only used behind a full output register
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid with empty output register");

    // A tick taken while the output stalls lands in the skid entry
    a_stall_spills: assert property (@(posedge clk) disable iff (!rst_n)
        (tick_accept && out_valid_reg && !result.ready) |=> skid_valid_reg)
        else $error("stalled tick not captured in skid entry");

    // Off mode keeps all duties at zero
    a_off_dark: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_OFF) |->
        (red_reg == DUTY_ZERO && blue_reg == DUTY_ZERO && purple_reg == DUTY_ZERO))
        else $error("duty nonzero in off mode");

    // On mode keeps all duties at full
    a_on_full: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_ON) |->
        (red_reg == DUTY_FULL && blue_reg == DUTY_FULL && purple_reg == DUTY_FULL))
        else $error("duty not full in on mode");
`endif

endmodule

`default_nettype wire

@@ tb/lms_checker.sv @@
// Checker for the LED mode sequencer: watches the tick, result and config
// channels, predicts each result beat and compares it with what the block gives.
// Depends on lms_pkg, lms_tick_if, lms_result_if and lms_cfg_if.
`default_nettype none

module lms_checker
    import lms_pkg::*;
(
    input  wire    clk,
    input  wire    rst_n,
    lms_tick_if    tick,
    lms_result_if  result,
    lms_cfg_if     cfg,
    output int     errors,
    output int     pending
);

    typedef struct packed {
        logic [DUTY_W-1:0] red;
        logic [DUTY_W-1:0] blue;
        logic [DUTY_W-1:0] purple;
        mode_t             mode;
    } led_drive_t;

    // Shadow copy of the settings
    logic [ELAPSED_W-1:0] lockout;
    logic [ELAPSED_W-1:0] blink_period;
    logic [ELAPSED_W-1:0] fade_period;
    logic [DUTY_W-1:0]    fade_step;

    // Shadow copy of the sequencer state
    mode_t                mode;
    logic                 prev_mode_btn;
    logic                 prev_reset_btn;
    logic [ELAPSED_W-1:0] press_age;
    logic [ELAPSED_W-1:0] update_age;
    logic                 blink_lit;
    logic [DUTY_W-1:0]    fade_level;
    logic                 fade_rising;
    led_drive_t           duties;

    led_drive_t expected_leds[$];

    // Advance the shadow state by one millisecond tick; return the new outputs
    function automatic led_drive_t step_leds(input logic mode_btn, input logic reset_btn);
        logic [DUTY_W:0]   level_sum;
        logic [DUTY_W-1:0] blink_duty;
        press_age  = (press_age >= ELAPSED_MAX) ? ELAPSED_MAX : press_age + 1'b1;
        update_age = (update_age >= ELAPSED_MAX) ? ELAPSED_MAX : update_age + 1'b1;

        // Falling edges, judged against the lockout; mode button goes first
        if (!mode_btn && prev_mode_btn && press_age > lockout)
        begin
            mode      = mode_t'(mode + 2'd1);
            press_age = '0;
        end
        if (!reset_btn && prev_reset_btn && press_age > lockout)
        begin
            mode      = MODE_OFF;
            press_age = '0;
        end
        prev_mode_btn  = mode_btn;
        prev_reset_btn = reset_btn;

        case (mode)
            MODE_OFF:
            begin
                duties.red    = DUTY_ZERO;
                duties.blue   = DUTY_ZERO;
                duties.purple = DUTY_ZERO;
            end
            MODE_BLINK:
            begin
                if (update_age >= blink_period)
                begin
                    blink_lit     = !blink_lit;
                    blink_duty    = blink_lit ? DUTY_FULL : DUTY_ZERO;
                    duties.red    = blink_duty;
                    duties.blue   = blink_duty;
                    duties.purple = blink_duty;
                    update_age    = '0;
                end
            end
            MODE_ON:
            begin
                duties.red    = DUTY_FULL;
                duties.blue   = DUTY_FULL;
                duties.purple = DUTY_FULL;
            end
            default:
            begin
                // Triangle level, clamped at both ends; turn around at an end
                if (update_age >= fade_period)
                begin
                    if (fade_rising)
                    begin
                        level_sum  = {1'b0, fade_level} + {1'b0, fade_step};
                        fade_level = (level_sum > {1'b0, DUTY_FULL}) ? DUTY_FULL
                                                                    : level_sum[DUTY_W-1:0];
                    end
                    else
                    begin
                        fade_level = (fade_step >= fade_level) ? DUTY_ZERO
                                                               : fade_level - fade_step;
                    end
                    if (fade_level == DUTY_FULL || fade_level == DUTY_ZERO)
                        fade_rising = !fade_rising;
                    duties.red    = fade_level;
                    duties.blue   = DUTY_FULL - fade_level;
                    duties.purple = (fade_level >> 1) + PURPLE_OFS;
                    update_age    = '0;
                end
            end
        endcase
        duties.mode = mode;
        return duties;
    endfunction

    task automatic report(input string field, input int want, input int got);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        errors++;
    endtask

    // Track settings, check result beats in order, predict each tick beat
    always @(posedge clk or negedge rst_n)
    begin
        led_drive_t want;
        if (!rst_n)
        begin
            lockout        = LOCKOUT_RST;
            blink_period   = BLINK_PERIOD_RST;
            fade_period    = FADE_PERIOD_RST;
            fade_step      = FADE_STEP_RST;
            mode           = MODE_OFF;
            prev_mode_btn  = 1'b1;
            prev_reset_btn = 1'b1;
            press_age      = '0;
            update_age     = '0;
            blink_lit      = 1'b0;
            fade_level     = DUTY_ZERO;
            fade_rising    = 1'b1;
            duties         = '0;
            expected_leds.delete();
            errors         = 0;
            pending        = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg_index_t'(cfg.index))
                    CFG_LOCKOUT:      lockout      = cfg.data;
                    CFG_BLINK_PERIOD: blink_period = cfg.data;
                    CFG_FADE_PERIOD:  fade_period  = cfg.data;
                    CFG_FADE_STEP:    fade_step    = cfg.data[DUTY_W-1:0];
                    default:          ;
                endcase
            end

            // A result beat always belongs to an earlier tick, so check it first
            if (result.valid && result.ready)
            begin
                if (expected_leds.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected, actual r=%0d b=%0d p=%0d m=%0d",
                             $time, result.red_duty, result.blue_duty, result.purple_duty,
                             result.current_mode);
                    errors++;
                end
                else
                begin
                    want = expected_leds.pop_front();
                    if (result.red_duty !== want.red)
                        report("red_duty", want.red, result.red_duty);
                    if (result.blue_duty !== want.blue)
                        report("blue_duty", want.blue, result.blue_duty);
                    if (result.purple_duty !== want.purple)
                        report("purple_duty", want.purple, result.purple_duty);
                    if (result.current_mode !== want.mode)
                        report("current_mode", want.mode, result.current_mode);
                end
            end

            if (tick.valid && tick.ready)
                expected_leds.push_back(step_leds(tick.mode_button_level,
                                                  tick.reset_button_level));
            pending = expected_leds.size();
        end
    end

endmodule

`default_nettype wire

@@ tb/led_mode_sequencer_tb.sv @@
// Testbench top for the LED mode sequencer: clock, reset, tick and config
// stimulus, result back-pressure and the final verdict.
// Depends on lms_pkg, the three channel interfaces, led_mode_sequencer and lms_checker.
`default_nettype none

module led_mode_sequencer_tb;
    import lms_pkg::*;

    localparam int TICK_TARGET     = 1550;
    localparam int HOLD_OFF_CYCLES = 40;
    localparam int SETTLE_CYCLES   = 10;
    localparam int CYCLE_LIMIT     = 1000000;

    logic clk = 1'b0;
    logic rst_n;
    int   mismatches;
    int   pending;
    int   ticks_sent;
    int   cycle_count = 0;
    bit   calm;
    bit   hold_off_req;

    lms_tick_if   tick();
    lms_result_if result();
    lms_cfg_if    cfg();

    led_mode_sequencer dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .tick   (tick),
        .result (result),
        .cfg    (cfg)
    );

    lms_checker u_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .tick    (tick),
        .result  (result),
        .cfg     (cfg),
        .errors  (mismatches),
        .pending (pending)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Mostly no gap, some short ones, a few long; none while calm
    function automatic int pick_gap();
        int roll;
        if (calm)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [ELAPSED_W-1:0] pick_period();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10)
            return 9'd1;
        if (roll < 15)
            return 9'd511;
        if (roll < 80)
            return ELAPSED_W'($urandom_range(1, 12));
        return ELAPSED_W'($urandom_range(1, 511));
    endfunction

    // Offer one tick beat after a random gap; return at the negedge after it is taken
    task automatic send_tick(input logic mode_btn, input logic reset_btn);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            tick.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        tick.valid              = 1'b1;
        tick.mode_button_level  = mode_btn;
        tick.reset_button_level = reset_btn;
        do @(posedge clk); while (!tick.ready);
        @(negedge clk);
        ticks_sent++;
    endtask

    // Drop the tick side and hold until every result beat is back
    task automatic drain_results();
        tick.valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_W-1:0] value);
        cfg.valid = 1'b1;
        cfg.index = idx;
        cfg.data  = value;
        do @(posedge clk); while (!cfg.ready);
        @(negedge clk);
    endtask

    task automatic load_settings(input logic [ELAPSED_W-1:0] lock,
                                 input logic [ELAPSED_W-1:0] blink,
                                 input logic [ELAPSED_W-1:0] fade,
                                 input logic [DUTY_W-1:0]    step);
        write_reg(CFG_LOCKOUT, lock);
        write_reg(CFG_BLINK_PERIOD, blink);
        write_reg(CFG_FADE_PERIOD, fade);
        write_reg(CFG_FADE_STEP, {1'b0, step});
        cfg.valid = 1'b0;
    endtask

    // Button waveforms: held levels of random length, with some noisy ticks mixed in
    task automatic run_phase(input int count, input int noise_pct);
        logic mode_btn;
        logic reset_btn;
        int   mode_run;
        int   reset_run;
        mode_btn  = 1'b1;
        reset_btn = 1'b1;
        mode_run  = $urandom_range(1, 6);
        reset_run = $urandom_range(4, 30);
        repeat (count)
        begin
            if ($urandom_range(0, 99) < noise_pct)
            begin
                send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
            else
            begin
                send_tick(mode_btn, reset_btn);
                mode_run--;
                if (mode_run == 0)
                begin
                    mode_btn = !mode_btn;
                    mode_run = mode_btn ? $urandom_range(1, 8) : $urandom_range(1, 4);
                end
                reset_run--;
                if (reset_run == 0)
                begin
                    reset_btn = !reset_btn;
                    reset_run = reset_btn ? $urandom_range(5, 40) : $urandom_range(1, 3);
                end
            end
        end
    endtask

    // Result side: ready runs broken by random stalls, plus a long hold-off on request
    initial
    begin
        int stall;
        result.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                result.ready = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                hold_off_req = 1'b0;
            end
            result.ready = 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge clk);
            stall = pick_gap();
            if (stall > 0)
            begin
                result.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
        end
    end

    initial
    begin
        int                   phase_no;
        int                   roll;
        logic [ELAPSED_W-1:0] lock;
        logic [DUTY_W-1:0]    step;

        tick.valid              = 1'b0;
        tick.mode_button_level  = 1'b1;
        tick.reset_button_level = 1'b1;
        cfg.valid               = 1'b0;
        cfg.index               = CFG_LOCKOUT;
        cfg.data                = '0;
        calm                    = 1'b0;
        hold_off_req            = 1'b0;
        ticks_sent              = 0;
        rst_n                   = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: a press right after reset falls inside the lockout
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b1);
        drain_results();

        // No lockout, fastest blink and fade, largest step: walk every mode
        load_settings(9'd0, 9'd1, 9'd1, 8'd255);
        send_tick(1'b0, 1'b1);  // blink
        send_tick(1'b1, 1'b1);  // blink toggles back
        send_tick(1'b0, 1'b1);  // on
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b1);  // fade, reaches full and turns
        send_tick(1'b1, 1'b1);  // clamps at zero
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b1);  // wraps to off
        send_tick(1'b0, 1'b0);  // reset edge only
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b0);  // both edges: mode wins
        send_tick(1'b0, 1'b0);  // held low, no edge
        send_tick(1'b1, 1'b0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b1, 1'b0);  // reset from blink
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b1);  // fade
        send_tick(1'b1, 1'b1);
        send_tick(1'b1, 1'b0);  // reset from fade
        drain_results();

        // Largest lockout and periods: presses only after the elapsed counter saturates
        load_settings(9'd510, 9'd511, 9'd511, 8'd1);
        run_phase(560, 0);
        drain_results();

        phase_no = 0;
        while (ticks_sent < TICK_TARGET)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 10)
                lock = 9'd0;
            else if (roll < 13)
                lock = 9'd510;
            else if (roll < 70)
                lock = ELAPSED_W'($urandom_range(0, 6));
            else if (roll < 90)
                lock = ELAPSED_W'($urandom_range(0, 40));
            else
                lock = ELAPSED_W'($urandom_range(0, 510));
            roll = $urandom_range(0, 99);
            if (roll < 10)
                step = 8'd1;
            else if (roll < 20)
                step = 8'd255;
            else
                step = DUTY_W'($urandom_range(1, 255));
            load_settings(lock, pick_period(), pick_period(), step);

            // Some phases run gap-free; two phases, one of them gap-free, also hold off the result side
            calm = (phase_no % 4 == 3) || phase_no == 2;
            if (phase_no == 2 || phase_no == 9)
                hold_off_req = 1'b1;
            run_phase($urandom_range(40, 110), (phase_no % 5 == 4) ? 60 : 10);
            drain_results();
            calm = 1'b0;
            phase_no++;
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire

@@ filelist.f @@
src/lms_pkg.sv
src/lms_tick_if.sv
src/lms_result_if.sv
src/lms_cfg_if.sv
src/led_mode_sequencer.sv
tb/lms_checker.sv
tb/led_mode_sequencer_tb.sv
